>>> design/pgw_pkg.sv
package pgw_pkg;

   localparam int ADDR_WIDTH  = 48;
   localparam int ENTRY_WIDTH = 64;
   localparam int IDX_WIDTH   = 9;
   localparam int PAGE_SHIFT  = 12;

   // Entries in one table page; the slot index is IDX_WIDTH bits wide.
   localparam int ENTRIES_PER_TABLE = 512;

   // Low bit of each virtual address index, root level first.
   localparam int L0_SHIFT = 39;
   localparam int L1_SHIFT = 30;
   localparam int L2_SHIFT = 21;
   localparam int L3_SHIFT = 12;

   typedef logic [ADDR_WIDTH-1:0]  addr_type;
   typedef logic [ENTRY_WIDTH-1:0] entry_type;
   typedef logic [IDX_WIDTH-1:0]   idx_type;
   typedef logic [1:0]             level_type;
   typedef logic [1:0]             status_type;
   typedef logic [3:0]             page_out_type;
   typedef logic [2:0]             csr_index_type;

   localparam status_type STATUS_OK          = 2'd0;
   localparam status_type STATUS_NOT_MAPPED  = 2'd1;
   localparam status_type STATUS_NO_PAGES    = 2'd2;
   localparam status_type STATUS_OUTSIDE     = 2'd3;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_MAP    = 1'b1;

   localparam csr_index_type CSR_TABLE_BASE  = 3'd0;
   localparam csr_index_type CSR_DESC_BITS   = 3'd1;
   localparam csr_index_type CSR_NORMAL_ATTR = 3'd2;
   localparam csr_index_type CSR_DEVICE_ATTR = 3'd3;
   localparam csr_index_type CSR_USER_ACCESS = 3'd4;

   localparam level_type LEVEL_LEAF = 2'd3;

endpackage

>>> design/pgw_req_if.sv
interface pgw_req_if;
   import pgw_pkg::*;

   logic     valid;
   logic     ready;
   logic     opcode;
   addr_type virt_addr;
   addr_type phys_addr;
   logic     attr_kind;

   modport source (output valid, output opcode, output virt_addr, output phys_addr,
                   output attr_kind, input ready);
   modport sink   (input valid, input opcode, input virt_addr, input phys_addr,
                   input attr_kind, output ready);
endinterface

>>> design/pgw_rsp_if.sv
interface pgw_rsp_if;
   import pgw_pkg::*;

   logic         valid;
   logic         ready;
   status_type   status;
   entry_type    entry_value;
   page_out_type entry_page;
   idx_type      entry_slot;

   modport source (output valid, output status, output entry_value, output entry_page,
                   output entry_slot, input ready);
   modport sink   (input valid, input status, input entry_value, input entry_page,
                   input entry_slot, output ready);
endinterface

>>> design/page_table_walk_and_map.sv
// For each table level a walk issues the store read address, then evaluates the registered
// read data. Items are handled one at a time: a new request is taken only once the previous
// result has moved into the output register.
// Reset (synchronous, active high) runs a clearing pass that zeroes the table store, one
// entry per cycle; no request is taken until it ends.
// Configuration writes are taken in every cycle, also during the clearing pass.
module page_table_walk_and_map #(
   parameter int NUM_TABLE_PAGES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   pgw_req_if.sink                req,
   pgw_rsp_if.source              rsp,
   input  logic                   csr_we,
   input  pgw_pkg::csr_index_type csr_index,
   input  pgw_pkg::entry_type     csr_wdata
);
   import pgw_pkg::*;

   // Store geometry. A store address is the page number above the 9-bit slot index.
   localparam int DEPTH = NUM_TABLE_PAGES * ENTRIES_PER_TABLE;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(NUM_TABLE_PAGES);
   // The bump pointer can reach NUM_TABLE_PAGES itself once every page is used.
   localparam int NFW   = $clog2(NUM_TABLE_PAGES + 1);
   localparam int HIW   = ENTRY_WIDTH - PAGE_SHIFT;

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RD    = 3'd2;
   localparam logic [2:0] ST_EVAL  = 3'd3;
   localparam logic [2:0] ST_ALLOC = 3'd4;
   localparam logic [2:0] ST_WR    = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   // Configuration registers.
   addr_type                base_ff;
   logic [PAGE_SHIFT-1:0]   desc_bits_ff;
   entry_type               normal_attr_ff;
   entry_type               device_attr_ff;
   entry_type               user_access_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff        <= '0;
         desc_bits_ff   <= 12'd3;
         normal_attr_ff <= '0;
         device_attr_ff <= '0;
         user_access_ff <= 64'd64;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TABLE_BASE:  base_ff        <= csr_wdata[ADDR_WIDTH-1:0];
            CSR_DESC_BITS:   desc_bits_ff   <= csr_wdata[PAGE_SHIFT-1:0];
            CSR_NORMAL_ATTR: normal_attr_ff <= csr_wdata;
            CSR_DEVICE_ATTR: device_attr_ff <= csr_wdata;
            CSR_USER_ACCESS: user_access_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Walk state.
   logic [2:0]      state_ff,   state_in;
   logic [AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [NFW-1:0]  nfp_ff,     nfp_in;
   logic            op_ff,      op_in;
   addr_type        va_ff,      va_in;
   addr_type        pa_ff,      pa_in;
   logic            kind_ff,    kind_in;
   level_type       level_ff,   level_in;
   logic [PW-1:0]   page_ff,    page_in;

   // Finished result, waiting for the output register.
   status_type      res_status_ff, res_status_in;
   entry_type       res_value_ff,  res_value_in;
   logic [PW-1:0]   res_page_ff,   res_page_in;
   idx_type         res_slot_ff,   res_slot_in;

   // Output register.
   logic            rsp_valid_ff,  rsp_valid_in;
   status_type      rsp_status_ff, rsp_status_in;
   entry_type       rsp_value_ff,  rsp_value_in;
   page_out_type    rsp_page_ff,   rsp_page_in;
   idx_type         rsp_slot_ff,   rsp_slot_in;

   // Store port.
   logic            ram_wr_en;
   logic [AW-1:0]   ram_wr_addr;
   entry_type       ram_wr_data;
   logic            ram_rd_en;
   logic [AW-1:0]   ram_rd_addr;
   entry_type       ram_rd_data;

   pgw_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   function automatic idx_type level_idx(input addr_type va, input level_type lvl);
      idx_type r;
      case (lvl)
         2'd0:    r = va[L0_SHIFT +: IDX_WIDTH];
         2'd1:    r = va[L1_SHIFT +: IDX_WIDTH];
         2'd2:    r = va[L2_SHIFT +: IDX_WIDTH];
         default: r = va[L3_SHIFT +: IDX_WIDTH];
      endcase
      return r;
   endfunction

   idx_type         cur_idx;
   logic [HIW-1:0]  base_hi;
   logic [HIW-1:0]  desc_hi;
   logic [HIW-1:0]  desc_diff;
   logic            desc_outside;
   logic [NFW:0]    alloc_sum;
   logic            alloc_fail;
   entry_type       new_desc;
   entry_type       leaf_value;
   logic [PW+3:0]   res_page_ext;

   assign cur_idx   = level_idx(va_ff, level_ff);
   assign base_hi   = {{(HIW-(ADDR_WIDTH-PAGE_SHIFT)){1'b0}}, base_ff[ADDR_WIDTH-1:PAGE_SHIFT]};

   // A descriptor leaves the store when it points below the base or past the last page.
   assign desc_hi      = ram_rd_data[ENTRY_WIDTH-1:PAGE_SHIFT];
   assign desc_diff    = desc_hi - base_hi;
   assign desc_outside = (desc_hi < base_hi) || (desc_diff >= HIW'(NUM_TABLE_PAGES));

   // A map missing at level L needs 3 - L fresh pages; the walk level holds L here.
   assign alloc_sum  = {1'b0, nfp_ff} + ((NFW+1)'(3) - (NFW+1)'(level_ff));
   assign alloc_fail = alloc_sum > (NFW+1)'(NUM_TABLE_PAGES);

   // New table descriptor: page address of the next free page with the table bits below.
   assign new_desc   = {base_hi + HIW'(nfp_ff), desc_bits_ff};
   assign leaf_value = {{(ENTRY_WIDTH-ADDR_WIDTH){1'b0}}, pa_ff}
                     | (kind_ff ? device_attr_ff : normal_attr_ff)
                     | user_access_ff;

   // The page number is reported in four bits, zero-extended or truncated.
   assign res_page_ext = {4'b0, res_page_ff};

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      nfp_in        = nfp_ff;
      op_in         = op_ff;
      va_in         = va_ff;
      pa_in         = pa_ff;
      kind_in       = kind_ff;
      level_in      = level_ff;
      page_in       = page_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_page_in   = res_page_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_slot_in   = rsp_slot_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = {page_ff, cur_idx};
      ram_wr_data   = new_desc;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = {page_ff, cur_idx};

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               op_in    = req.opcode;
               va_in    = req.virt_addr;
               pa_in    = req.phys_addr;
               kind_in  = req.attr_kind;
               level_in = '0;
               page_in  = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            // Failures report zero in every field but the status.
            res_value_in = '0;
            res_page_in  = '0;
            res_slot_in  = '0;
            if (level_ff == LEVEL_LEAF) begin
               res_status_in = STATUS_OK;
               res_value_in  = ram_rd_data;
               res_page_in   = page_ff;
               res_slot_in   = cur_idx;
               state_in      = ST_FIN;
            end else if (!ram_rd_data[0]) begin
               if (op_ff == OP_MAP) begin
                  state_in = ST_ALLOC;
               end else begin
                  res_status_in = STATUS_NOT_MAPPED;
                  state_in      = ST_FIN;
               end
            end else if (desc_outside) begin
               res_status_in = STATUS_OUTSIDE;
               state_in      = ST_FIN;
            end else begin
               page_in  = desc_diff[PW-1:0];
               level_in = level_ff + 2'd1;
               // A map writes the leaf without reading it first.
               if (level_ff == 2'd2 && op_ff == OP_MAP) begin
                  state_in = ST_WR;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_ALLOC: begin
            // Nothing is written unless every missing level can get a page.
            if (alloc_fail) begin
               res_status_in = STATUS_NO_PAGES;
               res_value_in  = '0;
               res_page_in   = '0;
               res_slot_in   = '0;
               state_in      = ST_FIN;
            end else begin
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            ram_wr_en = 1'b1;
            if (level_ff == LEVEL_LEAF) begin
               ram_wr_data   = leaf_value;
               res_status_in = STATUS_OK;
               res_value_in  = leaf_value;
               res_page_in   = page_ff;
               res_slot_in   = cur_idx;
               state_in      = ST_FIN;
            end else begin
               // Link in the next free page; it is still all zero from the clearing pass.
               page_in  = nfp_ff[PW-1:0];
               nfp_in   = nfp_ff + NFW'(1);
               level_in = level_ff + 2'd1;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_page_in   = res_page_ext[3:0];
               rsp_slot_in   = res_slot_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         nfp_ff       <= NFW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         nfp_ff       <= nfp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      va_ff         <= va_in;
      pa_ff         <= pa_in;
      kind_ff       <= kind_in;
      level_ff      <= level_in;
      page_ff       <= page_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_page_ff   <= res_page_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // A request beat is taken only between items; the response beat leaves the output register.
   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.entry_value = rsp_value_ff;
   assign rsp.entry_page  = rsp_page_ff;
   assign rsp.entry_slot  = rsp_slot_ff;

endmodule

>>> design/pgw_ram.sv
module pgw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> bench/tb_page_table_walk_and_map.sv
module tb_page_table_walk_and_map;
   import pgw_pkg::*;

   // Store geometry of the instance under test.
   localparam int NUM_TABLE_PAGES = 16;
   // Every index that the register port can carry; the ones above the last
   // register must be ignored by the block.
   localparam int CSR_INDEX_COUNT = 8;
   // Hard stop. It leaves room for the clearing pass after reset and for
   // slow items with heavy idling on both sides.
   localparam int CYCLE_LIMIT = 400000;
   // Items in each of the three random phases.
   localparam int RANDOM_ITEMS = 210;
   // Cycles allowed for stray beats after the last expected response.
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_REPORTS = 10;

   // One request beat and one response beat, field for field.
   typedef struct packed {
      logic     opcode;
      addr_type virt_addr;
      addr_type phys_addr;
      logic     attr_kind;
   } map_request;

   typedef struct packed {
      status_type   status;
      entry_type    entry_value;
      page_out_type entry_page;
      idx_type      entry_slot;
   } map_outcome;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   entry_type     csr_wdata;

   pgw_req_if req_if ();
   pgw_rsp_if rsp_if ();

   page_table_walk_and_map #(
      .NUM_TABLE_PAGES(NUM_TABLE_PAGES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow copy of the block: the table store, the page allocator and the
   // five registers. Only the monitor touches these once reset is over.
   entry_type   shadow_table [NUM_TABLE_PAGES * ENTRIES_PER_TABLE];
   int unsigned shadow_next_page;
   addr_type    shadow_base;
   logic [11:0] shadow_desc_bits;
   entry_type   shadow_normal_attr;
   entry_type   shadow_device_attr;
   entry_type   shadow_user_bits;

   // Requests waiting to be sent, in order; the head is the one on the bus.
   map_request  request_backlog [$];
   // Predicted responses, oldest first.
   map_outcome  expected_walks [$];
   // Virtual addresses that some map request has used. Random requests are
   // mostly built around them so that they land in tables that exist.
   addr_type    mapped_addrs [$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   logic        req_beat_seen;
   int          fail_count;
   int          cycle_count;
   map_request  req_seen;
   map_outcome  rsp_seen;
   map_outcome  rsp_wanted;

   function automatic int unsigned slot_of(input int unsigned page, input idx_type idx);
      return page * ENTRIES_PER_TABLE + idx;
   endfunction

   // Walk the shadow tables for one request and apply its side effects. A map
   // checks every level first, so a request that fails changes nothing.
   function automatic map_outcome predict_walk(input map_request r);
      idx_type     lvl_idx [4];
      int unsigned cur_page;
      int          first_gap;
      int          lvl;
      int unsigned need;
      entry_type   desc;
      logic [63:0] target;
      logic [63:0] base_aligned;
      map_outcome  o;
      lvl_idx[0]   = r.virt_addr[L0_SHIFT +: IDX_WIDTH];
      lvl_idx[1]   = r.virt_addr[L1_SHIFT +: IDX_WIDTH];
      lvl_idx[2]   = r.virt_addr[L2_SHIFT +: IDX_WIDTH];
      lvl_idx[3]   = r.virt_addr[L3_SHIFT +: IDX_WIDTH];
      cur_page     = 0;
      first_gap    = -1;
      o            = '0;
      base_aligned = {16'h0000, shadow_base[ADDR_WIDTH-1:PAGE_SHIFT], 12'h000};

      // Three intermediate levels. A clear valid bit ends the walk; a set one
      // must point at a page inside the store.
      for (lvl = 0; lvl < 3; lvl++) begin
         desc = shadow_table[slot_of(cur_page, lvl_idx[lvl])];
         if (!desc[0]) begin
            first_gap = lvl;
            break;
         end
         target = {desc[ENTRY_WIDTH-1:PAGE_SHIFT], 12'h000};
         if (target < base_aligned ||
             ((target - base_aligned) >> PAGE_SHIFT) >= NUM_TABLE_PAGES) begin
            o.status = STATUS_OUTSIDE;
            return o;
         end
         cur_page = int'((target - base_aligned) >> PAGE_SHIFT);
      end

      if (first_gap >= 0) begin
         if (r.opcode == OP_LOOKUP) begin
            o.status = STATUS_NOT_MAPPED;
            return o;
         end
         need = 3 - first_gap;
         if (shadow_next_page > NUM_TABLE_PAGES || NUM_TABLE_PAGES - shadow_next_page < need) begin
            o.status = STATUS_NO_PAGES;
            return o;
         end
         // Link in fresh pages from the bump pointer, one per missing level.
         for (lvl = first_gap; lvl < 3; lvl++) begin
            shadow_table[slot_of(cur_page, lvl_idx[lvl])] =
               (base_aligned + (64'(shadow_next_page) << PAGE_SHIFT)) |
               {52'h0, shadow_desc_bits};
            cur_page = shadow_next_page;
            shadow_next_page++;
         end
      end

      if (r.opcode == OP_MAP)
         shadow_table[slot_of(cur_page, lvl_idx[3])] =
            {16'h0000, r.phys_addr} |
            (r.attr_kind ? shadow_device_attr : shadow_normal_attr) | shadow_user_bits;

      o.status      = STATUS_OK;
      o.entry_value = shadow_table[slot_of(cur_page, lvl_idx[3])];
      o.entry_page  = cur_page[3:0];
      o.entry_slot  = lvl_idx[3];
      return o;
   endfunction

   function automatic addr_type va_of(input idx_type l0, input idx_type l1,
                                      input idx_type l2, input idx_type l3);
      return {l0, l1, l2, l3, 12'h000};
   endfunction

   function automatic addr_type rand_addr();
      return addr_type'({$urandom(), $urandom()});
   endfunction

   function automatic entry_type rand_entry();
      return {$urandom(), $urandom()};
   endfunction

   task automatic queue_item(input logic op, input addr_type va, input addr_type pa,
                             input logic kind);
      map_request r;
      r.opcode    = op;
      r.virt_addr = va;
      r.phys_addr = pa;
      r.attr_kind = kind;
      request_backlog.push_back(r);
      if (op == OP_MAP)
         mapped_addrs.push_back(va);
   endtask

   // Hold off until every queued request has been sent and answered. The
   // block is idle afterwards, since every request gets exactly one response.
   task automatic drain();
      while (request_backlog.size() != 0 || expected_walks.size() != 0)
         @(negedge clock);
   endtask

   // Consecutive calls keep the write enable high; close_reg_writes drops it.
   task automatic write_reg(input csr_index_type idx, input entry_type value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic close_reg_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Random requests. Most reuse the upper levels of an address that has been
   // mapped before: the same leaf, a new leaf in the same last-level table, or
   // a new branch under the same third-level table. The rest are anywhere in
   // the address space and mostly find the root entry empty.
   task automatic run_random(input int count);
      map_request r;
      addr_type   seed_va;
      int         n;
      int unsigned pick;
      for (n = 0; n < count; n++) begin
         r.opcode    = 1'($urandom_range(1));
         r.phys_addr = rand_addr();
         r.attr_kind = 1'($urandom_range(1));
         seed_va     = mapped_addrs[$urandom_range(mapped_addrs.size() - 1)];
         pick        = $urandom_range(99);
         if (pick < 40)
            r.virt_addr = {seed_va[ADDR_WIDTH-1:L3_SHIFT], 12'($urandom())};
         else if (pick < 70)
            r.virt_addr = {seed_va[ADDR_WIDTH-1:L2_SHIFT], 9'($urandom()), 12'($urandom())};
         else if (pick < 85)
            r.virt_addr = {seed_va[ADDR_WIDTH-1:L1_SHIFT], 18'($urandom()), 12'($urandom())};
         else
            r.virt_addr = rand_addr();
         queue_item(r.opcode, r.virt_addr, r.phys_addr, r.attr_kind);
      end
      drain();
   endtask

   // Request driver. A new beat is offered only when the bus is empty or the
   // previous beat went through at the last rising edge; valid is decided once
   // per falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_beat_seen) begin
         if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid     <= 1'b1;
            req_if.opcode    <= request_backlog[0].opcode;
            req_if.virt_addr <= request_backlog[0].virt_addr;
            req_if.phys_addr <= request_backlog[0].phys_addr;
            req_if.attr_kind <= request_backlog[0].attr_kind;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response back-pressure, drawn fresh every cycle.
   always @(negedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor. Everything that changes the shadow state happens here, in the
   // order the block sees it: register writes, then accepted requests, and
   // each response beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         req_beat_seen = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TABLE_BASE:  shadow_base        = csr_wdata[ADDR_WIDTH-1:0];
               CSR_DESC_BITS:   shadow_desc_bits   = csr_wdata[11:0];
               CSR_NORMAL_ATTR: shadow_normal_attr = csr_wdata;
               CSR_DEVICE_ATTR: shadow_device_attr = csr_wdata;
               CSR_USER_ACCESS: shadow_user_bits   = csr_wdata;
               default: ;
            endcase
         end

         req_beat_seen = req_if.valid && req_if.ready;
         if (req_beat_seen) begin
            req_seen.opcode    = req_if.opcode;
            req_seen.virt_addr = req_if.virt_addr;
            req_seen.phys_addr = req_if.phys_addr;
            req_seen.attr_kind = req_if.attr_kind;
            request_backlog.delete(0);
            expected_walks.push_back(predict_walk(req_seen));
         end

         if (rsp_if.valid && rsp_if.ready) begin
            rsp_seen.status      = rsp_if.status;
            rsp_seen.entry_value = rsp_if.entry_value;
            rsp_seen.entry_page  = rsp_if.entry_page;
            rsp_seen.entry_slot  = rsp_if.entry_slot;
            if (expected_walks.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("Response with nothing pending: status %0d value %h page %0d slot %0d",
                           rsp_seen.status, rsp_seen.entry_value, rsp_seen.entry_page,
                           rsp_seen.entry_slot);
            end else begin
               rsp_wanted = expected_walks.pop_front();
               if (rsp_seen.status !== rsp_wanted.status ||
                   rsp_seen.entry_value !== rsp_wanted.entry_value ||
                   rsp_seen.entry_page !== rsp_wanted.entry_page ||
                   rsp_seen.entry_slot !== rsp_wanted.entry_slot) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $write("Mismatch at cycle %0d: status %0d/%0d value %h/%h ",
                            cycle_count, rsp_wanted.status, rsp_seen.status,
                            rsp_wanted.entry_value, rsp_seen.entry_value);
                     $display("page %0d/%0d slot %0d/%0d (expected/actual)",
                              rsp_wanted.entry_page, rsp_seen.entry_page,
                              rsp_wanted.entry_slot, rsp_seen.entry_slot);
                  end
               end
            end
         end
      end
   end

   // Watchdog for a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      addr_type  base_a;
      entry_type all_ones;
      int        spare;

      all_ones = '1;
      // A store base with junk in the low 12 bits, which the block ignores.
      base_a   = 48'h0000_ABCD_E5A5;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.opcode    = OP_LOOKUP;
      req_if.virt_addr = '0;
      req_if.phys_addr = '0;
      req_if.attr_kind = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_TABLE_BASE;
      csr_wdata        = '0;
      req_beat_seen    = 1'b0;
      fail_count       = 0;
      cycle_count      = 0;

      // Shadow state as the block leaves reset.
      foreach (shadow_table[i])
         shadow_table[i] = '0;
      shadow_next_page   = 1;
      shadow_base        = '0;
      shadow_desc_bits   = 12'h003;
      shadow_normal_attr = '0;
      shadow_device_attr = '0;
      shadow_user_bits   = 64'd64;

      // First idling mode: a rarely idle sender and a receiver that stalls
      // more often than not. It covers the directed part and the first
      // random phase.
      send_idle_pct = 11;
      recv_idle_pct = 58;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers may be written while the clearing pass runs. The indexes
      // past the last register are written too and must change nothing.
      write_reg(CSR_TABLE_BASE, {16'h0000, base_a});
      write_reg(CSR_DESC_BITS, 64'h5A3);
      write_reg(CSR_NORMAL_ATTR, rand_entry());
      write_reg(CSR_DEVICE_ATTR, rand_entry());
      write_reg(CSR_USER_ACCESS, rand_entry());
      for (spare = int'(CSR_USER_ACCESS) + 1; spare < CSR_INDEX_COUNT; spare++)
         write_reg(csr_index_type'(spare), all_ones);
      close_reg_writes();

      // Empty root, then the two corners of the address space with the
      // extreme physical pages. Then the three ways a lookup stops early or
      // late: a leaf that was never written still answers ok with zero, and
      // a missing second or third level answers not mapped. Then maps that
      // need one and two new pages, and a remap of an existing leaf.
      queue_item(OP_LOOKUP, va_of(0, 0, 0, 0), rand_addr(), 1'b1);
      queue_item(OP_MAP, va_of(0, 0, 0, 0), '0, 1'b0);
      queue_item(OP_LOOKUP, 48'h0000_0000_0FFF, rand_addr(), 1'b0);
      queue_item(OP_MAP, '1, '1, 1'b1);
      queue_item(OP_LOOKUP, '1, rand_addr(), 1'b0);
      queue_item(OP_LOOKUP, va_of(0, 0, 0, 5), rand_addr(), 1'b1);
      queue_item(OP_LOOKUP, va_of(0, 1, 0, 0), rand_addr(), 1'b0);
      queue_item(OP_LOOKUP, va_of(0, 0, 1, 0), rand_addr(), 1'b1);
      queue_item(OP_MAP, va_of(0, 0, 1, 7), rand_addr(), 1'b0);
      queue_item(OP_MAP, va_of(0, 2, 0, 0), rand_addr(), 1'b1);
      queue_item(OP_MAP, va_of(0, 0, 0, 0), rand_addr(), 1'b1);
      drain();

      // With the base at zero the existing descriptors point past the end of
      // the store: both a lookup and a map through them must be refused, and
      // the map must leave the tables alone. A fresh root slot still maps.
      write_reg(CSR_TABLE_BASE, '0);
      close_reg_writes();
      queue_item(OP_LOOKUP, va_of(0, 0, 0, 0), rand_addr(), 1'b0);
      queue_item(OP_MAP, va_of(0, 0, 0, 0), rand_addr(), 1'b0);
      queue_item(OP_MAP, va_of(5, 0, 0, 0), rand_addr(), 1'b1);
      drain();

      // Back to the first base: the old tree is reachable and unchanged, and
      // the tree built at base zero now points below the store. New
      // descriptors carry a clear valid bit, so a page linked in this way
      // looks missing and is replaced by the next map. The remaining pages
      // run out part way through, and a map that needs too many fails.
      write_reg(CSR_TABLE_BASE, {16'h0000, base_a});
      write_reg(CSR_DESC_BITS, 64'hFFE);
      close_reg_writes();
      queue_item(OP_LOOKUP, va_of(0, 0, 0, 0), rand_addr(), 1'b1);
      queue_item(OP_LOOKUP, va_of(5, 0, 0, 0), rand_addr(), 1'b0);
      queue_item(OP_MAP, va_of(0, 0, 2, 1), rand_addr(), 1'b0);
      queue_item(OP_LOOKUP, va_of(0, 0, 2, 1), rand_addr(), 1'b0);
      queue_item(OP_MAP, va_of(0, 0, 2, 1), rand_addr(), 1'b1);
      queue_item(OP_MAP, va_of(7, 0, 0, 0), rand_addr(), 1'b0);
      queue_item(OP_MAP, va_of(0, 0, 3, 0), rand_addr(), 1'b1);
      queue_item(OP_MAP, va_of(0, 0, 4, 0), rand_addr(), 1'b0);
      drain();

      // Highest base and extreme attribute values: everything linked so far
      // lies below the store, and an empty root slot has no pages left.
      write_reg(CSR_TABLE_BASE, {16'h0000, 48'hFFFF_FFFF_FFFF});
      write_reg(CSR_DESC_BITS, 64'hFFF);
      write_reg(CSR_NORMAL_ATTR, all_ones);
      write_reg(CSR_DEVICE_ATTR, '0);
      write_reg(CSR_USER_ACCESS, '0);
      close_reg_writes();
      queue_item(OP_LOOKUP, va_of(0, 0, 0, 0), rand_addr(), 1'b0);
      queue_item(OP_MAP, va_of(9, 0, 0, 0), rand_addr(), 1'b1);
      queue_item(OP_MAP, va_of(0, 0, 0, 0), rand_addr(), 1'b0);
      drain();

      // Random phase one, first idling mode.
      write_reg(CSR_TABLE_BASE, {16'h0000, base_a});
      write_reg(CSR_DESC_BITS, 64'h001);
      write_reg(CSR_NORMAL_ATTR, rand_entry());
      write_reg(CSR_DEVICE_ATTR, rand_entry());
      write_reg(CSR_USER_ACCESS, rand_entry());
      close_reg_writes();
      run_random(RANDOM_ITEMS);

      // Random phase two: the idling roles swap.
      send_idle_pct = 58;
      recv_idle_pct = 11;
      write_reg(CSR_NORMAL_ATTR, '0);
      write_reg(CSR_DEVICE_ATTR, all_ones);
      write_reg(CSR_USER_ACCESS, rand_entry());
      close_reg_writes();
      run_random(RANDOM_ITEMS);

      // Random phase three: no idling on either side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_TABLE_BASE, {16'h0000, base_a[ADDR_WIDTH-1:PAGE_SHIFT], 12'hFFF});
      write_reg(CSR_DESC_BITS, '0);
      write_reg(CSR_NORMAL_ATTR, rand_entry());
      write_reg(CSR_DEVICE_ATTR, rand_entry());
      write_reg(CSR_USER_ACCESS, rand_entry());
      close_reg_writes();
      run_random(RANDOM_ITEMS);

      // Give a stray response beat the chance to show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_walks.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> filelist.f
design/pgw_pkg.sv
design/pgw_req_if.sv
design/pgw_rsp_if.sv
design/pgw_ram.sv
design/page_table_walk_and_map.sv
bench/tb_page_table_walk_and_map.sv
